>>> rtl/aatc_pkg.sv
package aatc_pkg;

    localparam int NUM_DIGITS = 4;
    localparam int DIGIT_W    = 4;
    localparam int SCAN_POS_W = $clog2(NUM_DIGITS);

    // Runtime state codes.
    localparam logic [1:0] RUN_OTHER  = 2'd0;
    localparam logic [1:0] RUN_FAULT  = 2'd1;
    localparam logic [1:0] RUN_LOCKED = 2'd2;

    // Alarm level codes.
    localparam logic [1:0] LVL_NONE = 2'd0;
    localparam logic [1:0] LVL_LOW  = 2'd1;
    localparam logic [1:0] LVL_MID  = 2'd2;
    localparam logic [1:0] LVL_HIGH = 2'd3;

    typedef struct packed {
        logic       alarm_active;
        logic [1:0] run_state;
        logic [1:0] severity;
    } t_status;

    typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] t_digits;

    typedef struct packed {
        logic                  scan_strobe;
        logic [SCAN_POS_W-1:0] scan_digit;
        logic [DIGIT_W-1:0]    scan_value;
        logic                  pulse_10ms;
        logic                  pulse_100ms;
        logic                  pulse_500ms;
        logic                  pulse_1s;
        logic                  pulse_2s;
    } t_timebase;

endpackage

>>> rtl/aatc_timebase.sv
module aatc_timebase
    import aatc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_advance,
    input  t_digits   i_digits,
    output t_timebase o_tb
);

    // The tick count is held in mixed radix: 20 x 10 x 5 x 2 x 2 = 4000 ticks.
    logic [4:0]            r_q20,  n_q20;
    logic [3:0]            r_c10,  n_c10;
    logic [2:0]            r_c5,   n_c5;
    logic                  r_c2,   n_c2;
    logic                  r_c2b,  n_c2b;
    logic [SCAN_POS_W-1:0] r_digit_sel, n_digit_sel;

    logic wrap20, wrap200, wrap1000, wrap2000, wrap4000;

    always_comb begin
        wrap20   = (r_q20 == 5'd19);
        wrap200  = wrap20 && (r_c10 == 4'd9);
        wrap1000 = wrap200 && (r_c5 == 3'd4);
        wrap2000 = wrap1000 && r_c2;
        wrap4000 = wrap2000 && r_c2b;

        n_q20 = wrap20 ? 5'd0 : r_q20 + 5'd1;
        n_c10 = r_c10;
        if (wrap20) begin
            n_c10 = wrap200 ? 4'd0 : r_c10 + 4'd1;
        end
        n_c5 = r_c5;
        if (wrap200) begin
            n_c5 = wrap1000 ? 3'd0 : r_c5 + 3'd1;
        end
        n_c2  = wrap1000 ? ~r_c2  : r_c2;
        n_c2b = wrap2000 ? ~r_c2b : r_c2b;

        // The tick count parity is the parity of its low digit, since 20 is even.
        o_tb             = '0;
        o_tb.pulse_10ms  = wrap20;
        o_tb.pulse_100ms = wrap200;
        o_tb.pulse_500ms = wrap1000;
        o_tb.pulse_1s    = wrap2000;
        o_tb.pulse_2s    = wrap4000;
        n_digit_sel      = r_digit_sel;
        if (!n_q20[0]) begin
            o_tb.scan_strobe = 1'b1;
            o_tb.scan_digit  = r_digit_sel;
            o_tb.scan_value  = i_digits[r_digit_sel];
            n_digit_sel      = r_digit_sel + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q20       <= '0;
            r_c10       <= '0;
            r_c5        <= '0;
            r_c2        <= 1'b0;
            r_c2b       <= 1'b0;
            r_digit_sel <= '0;
        end else if (i_advance) begin
            r_q20       <= n_q20;
            r_c10       <= n_c10;
            r_c5        <= n_c5;
            r_c2        <= n_c2;
            r_c2b       <= n_c2b;
            r_digit_sel <= n_digit_sel;
        end
    end

endmodule

>>> rtl/aatc_buzzer.sv
module aatc_buzzer
    import aatc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_advance,
    input  logic    i_enable,
    input  t_status i_status,
    output logic    o_level
);

    localparam int TIMER_W = 11;

    logic [TIMER_W-1:0] r_timer, n_timer;
    logic               r_silent, n_silent;
    logic               r_level, n_level;

    logic [TIMER_W-1:0] bumped;
    logic [TIMER_W-1:0] on_len;
    logic [TIMER_W-1:0] off_len;
    logic               sound;

    always_comb begin
        bumped   = r_timer + 1'b1;
        n_timer  = r_timer;
        n_silent = r_silent;
        n_level  = r_level;
        on_len   = TIMER_W'(200);
        off_len  = TIMER_W'(200);
        sound    = 1'b1;

        if (i_status.run_state == RUN_FAULT) begin
            on_len  = TIMER_W'(100);
            off_len = TIMER_W'(1900);
        end else if (i_status.run_state == RUN_LOCKED) begin
            on_len  = TIMER_W'(200);
            off_len = TIMER_W'(200);
        end else begin
            case (i_status.severity)
                LVL_LOW: begin
                    on_len  = TIMER_W'(200);
                    off_len = TIMER_W'(1800);
                end
                LVL_MID: begin
                    on_len  = TIMER_W'(400);
                    off_len = TIMER_W'(600);
                end
                LVL_HIGH: begin
                    on_len  = TIMER_W'(200);
                    off_len = TIMER_W'(200);
                end
                default: sound = 1'b0;
            endcase
        end

        if (!i_enable || !i_status.alarm_active) begin
            n_level  = 1'b0;
            n_timer  = '0;
            n_silent = 1'b0;
        end else if (!sound) begin
            // An alarm without a level keeps the phase timer where it is.
            n_level = 1'b0;
        end else if (!r_silent) begin
            if (bumped >= on_len) begin
                n_timer  = '0;
                n_silent = 1'b1;
                n_level  = 1'b0;
            end else begin
                n_timer = bumped;
                n_level = ~r_level;
            end
        end else begin
            n_level = 1'b0;
            if (bumped >= off_len) begin
                n_timer  = '0;
                n_silent = 1'b0;
            end else begin
                n_timer = bumped;
            end
        end
    end

    assign o_level = n_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer  <= '0;
            r_silent <= 1'b0;
            r_level  <= 1'b0;
        end else if (i_advance) begin
            r_timer  <= n_timer;
            r_silent <= n_silent;
            r_level  <= n_level;
        end
    end

endmodule

>>> rtl/aatc_led.sv
module aatc_led
    import aatc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_advance,
    input  t_status    i_status,
    output logic [2:0] o_levels
);

    localparam int TIMER_W = 16;

    logic [TIMER_W-1:0] r_timer, n_timer;
    logic [2:0]         r_levels, n_levels;

    logic [TIMER_W-1:0] bumped;
    logic               alarm;
    logic               fault;

    always_comb begin
        bumped  = r_timer + 1'b1;
        n_timer = bumped;
        alarm   = r_levels[1];
        fault   = r_levels[2];

        if (!i_status.alarm_active) begin
            n_levels = 3'b001;
            n_timer  = '0;
        end else begin
            if (i_status.run_state == RUN_FAULT || i_status.run_state == RUN_LOCKED) begin
                if (bumped >= ((i_status.run_state == RUN_LOCKED) ? TIMER_W'(200)
                                                                   : TIMER_W'(1000))) begin
                    // Both LEDs follow the toggled alarm LED.
                    alarm   = ~alarm;
                    fault   = alarm;
                    n_timer = '0;
                end
            end else if (i_status.severity == LVL_LOW ||
                         i_status.severity == LVL_MID) begin
                if (bumped >= ((i_status.severity == LVL_LOW) ? TIMER_W'(1000)
                                                              : TIMER_W'(500))) begin
                    alarm   = ~alarm;
                    fault   = 1'b0;
                    n_timer = '0;
                end
            end else if (i_status.severity == LVL_HIGH) begin
                if (bumped >= TIMER_W'(200)) begin
                    alarm   = 1'b0;
                    fault   = ~fault;
                    n_timer = '0;
                end
            end
            // In any alarm state the normal LED goes dark.
            n_levels = {fault, alarm, 1'b0};
        end
    end

    assign o_levels = n_levels;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer  <= '0;
            r_levels <= '0;
        end else if (i_advance) begin
            r_timer  <= n_timer;
            r_levels <= n_levels;
        end
    end

endmodule

>>> rtl/alarm_annunciator_tick_controller.sv
// Alarm annunciator tick controller.
// Input channel (i_valid / o_ready): one beat per 0.5 ms timer tick, carrying the
// system status and the four display digits. Output channel (o_valid / i_ready):
// one beat per tick with the buzzer level, the three LED levels, a display scan
// step on every second tick and the 10 ms .. 2 s period pulses.
// Configuration: i_cfg_we writes i_cfg_wdata into the buzzer enable bit (1 after
// reset); write it only while no beat is in flight.
// A beat lands in an input register, and all tick work is done combinationally from
// there into the result register, which loads when the beat advances (the result
// register is empty or being taken); the result is then offered on o_valid.
// Throughput is one beat per cycle while the receiver does not stall, set by the
// single registered pass through the tick counters, buzzer and LED logic.
// Reset clears all timers, the scan position and the LEDs, and empties both
// registers. When the receiver stalls, the held result stays in place, one more
// beat waits in the input register, and o_ready then drops until the result
// register drains.
module alarm_annunciator_tick_controller
    import aatc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_wdata,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_alarm_active,
    input  logic [1:0]            i_run_state,
    input  logic [1:0]            i_severity,
    input  logic [DIGIT_W-1:0]    i_digit0,
    input  logic [DIGIT_W-1:0]    i_digit1,
    input  logic [DIGIT_W-1:0]    i_digit2,
    input  logic [DIGIT_W-1:0]    i_digit3,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_buzzer_out,
    output logic                  o_led_normal,
    output logic                  o_led_alarm,
    output logic                  o_led_fault,
    output logic                  o_scan_strobe,
    output logic [SCAN_POS_W-1:0] o_scan_digit,
    output logic [DIGIT_W-1:0]    o_scan_value,
    output logic                  o_pulse_10ms,
    output logic                  o_pulse_100ms,
    output logic                  o_pulse_500ms,
    output logic                  o_pulse_1s,
    output logic                  o_pulse_2s
);

    logic      r_buzzer_enable;
    logic      r_in_valid;
    t_status   r_status;
    t_digits   r_digits;
    logic      r_out_valid;
    logic      r_buzzer;
    logic [2:0] r_leds;
    t_timebase r_tb;

    logic      advance;
    logic      buzzer_next;
    logic [2:0] leds_next;
    t_timebase tb_next;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buzzer_enable <= 1'b1;
        end else if (i_cfg_we) begin
            r_buzzer_enable <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_status.alarm_active <= i_alarm_active;
            r_status.run_state    <= i_run_state;
            r_status.severity     <= i_severity;
            r_digits              <= {i_digit3, i_digit2, i_digit1, i_digit0};
        end
    end

    aatc_timebase u_timebase (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_digits  (r_digits),
        .o_tb      (tb_next)
    );

    aatc_buzzer u_buzzer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_enable  (r_buzzer_enable),
        .i_status  (r_status),
        .o_level   (buzzer_next)
    );

    aatc_led u_led (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_status  (r_status),
        .o_levels  (leds_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_buzzer <= buzzer_next;
            r_leds   <= leds_next;
            r_tb     <= tb_next;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_buzzer_out  = r_buzzer;
    assign o_led_normal  = r_leds[0];
    assign o_led_alarm   = r_leds[1];
    assign o_led_fault   = r_leds[2];
    assign o_scan_strobe = r_tb.scan_strobe;
    assign o_scan_digit  = r_tb.scan_digit;
    assign o_scan_value  = r_tb.scan_value;
    assign o_pulse_10ms  = r_tb.pulse_10ms;
    assign o_pulse_100ms = r_tb.pulse_100ms;
    assign o_pulse_500ms = r_tb.pulse_500ms;
    assign o_pulse_1s    = r_tb.pulse_1s;
    assign o_pulse_2s    = r_tb.pulse_2s;

endmodule

>>> dv/tb_alarm_annunciator_tick_controller.sv
`timescale 1ns / 1ps

module tb_alarm_annunciator_tick_controller;
    import aatc_pkg::*;

    localparam logic [1:0] RUN_SPARE      = 2'd3;
    localparam int         WATCHDOG_LIMIT = 3000;
    localparam int         HOLD_CYCLES    = 200;
    localparam int         REPORT_LIMIT   = 10;
    localparam int         DRAIN_CYCLES   = 10;

    typedef struct packed {
        t_status status;
        t_digits digits;
    } t_tick_item;

    typedef struct packed {
        logic      buzzer_out;
        logic      led_normal;
        logic      led_alarm;
        logic      led_fault;
        t_timebase timebase;
    } t_tick_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic                  i_cfg_wdata = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic                  i_alarm_active = 1'b0;
    logic [1:0]            i_run_state = RUN_OTHER;
    logic [1:0]            i_severity = LVL_NONE;
    logic [DIGIT_W-1:0]    i_digit0 = '0;
    logic [DIGIT_W-1:0]    i_digit1 = '0;
    logic [DIGIT_W-1:0]    i_digit2 = '0;
    logic [DIGIT_W-1:0]    i_digit3 = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic                  o_buzzer_out;
    logic                  o_led_normal;
    logic                  o_led_alarm;
    logic                  o_led_fault;
    logic                  o_scan_strobe;
    logic [SCAN_POS_W-1:0] o_scan_digit;
    logic [DIGIT_W-1:0]    o_scan_value;
    logic                  o_pulse_10ms;
    logic                  o_pulse_100ms;
    logic                  o_pulse_500ms;
    logic                  o_pulse_1s;
    logic                  o_pulse_2s;

    alarm_annunciator_tick_controller uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_alarm_active (i_alarm_active),
        .i_run_state    (i_run_state),
        .i_severity     (i_severity),
        .i_digit0       (i_digit0),
        .i_digit1       (i_digit1),
        .i_digit2       (i_digit2),
        .i_digit3       (i_digit3),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_buzzer_out   (o_buzzer_out),
        .o_led_normal   (o_led_normal),
        .o_led_alarm    (o_led_alarm),
        .o_led_fault    (o_led_fault),
        .o_scan_strobe  (o_scan_strobe),
        .o_scan_digit   (o_scan_digit),
        .o_scan_value   (o_scan_value),
        .o_pulse_10ms   (o_pulse_10ms),
        .o_pulse_100ms  (o_pulse_100ms),
        .o_pulse_500ms  (o_pulse_500ms),
        .o_pulse_1s     (o_pulse_1s),
        .o_pulse_2s     (o_pulse_2s)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Shadow copy of the annunciator state, in its reset condition.
    logic        buzzer_en   = 1'b1;
    logic [11:0] tick_cnt    = '0;
    logic [1:0]  digit_sel   = '0;
    logic [10:0] bz_timer    = '0;
    logic        bz_silent   = 1'b0;
    logic        bz_level    = 1'b0;
    logic [15:0] led_cnt     = '0;
    logic [2:0]  led_lv      = '0;

    t_tick_item   pending_ticks[$];
    t_tick_result expected_outputs[$];

    logic in_fire         = 1'b0;
    int   send_idle_pct   = 0;
    int   stall_pct       = 0;
    int   hold_requests   = 0;
    int   holds_served    = 0;
    int   hold_left       = 0;
    int   idle_cycles     = 0;
    int   ticks_sent      = 0;
    int   checked_count   = 0;
    int   mismatch_count  = 0;

    function automatic t_tick_result advance_tick(t_status st, t_digits dg);
        t_tick_result r;
        logic [10:0]  on_len;
        logic [10:0]  off_len;
        logic         timed;
        logic         alarm_lit;
        logic         fault_lit;
        r = '0;
        tick_cnt = tick_cnt + 12'd1;

        if (!buzzer_en || !st.alarm_active) begin
            bz_level  = 1'b0;
            bz_timer  = '0;
            bz_silent = 1'b0;
        end else begin
            timed   = 1'b1;
            on_len  = 11'd200;
            off_len = 11'd200;
            if (st.run_state == RUN_FAULT) begin
                on_len  = 11'd100;
                off_len = 11'd1900;
            end else if (st.run_state != RUN_LOCKED) begin
                case (st.severity)
                    LVL_LOW: begin
                        on_len  = 11'd200;
                        off_len = 11'd1800;
                    end
                    LVL_MID: begin
                        on_len  = 11'd400;
                        off_len = 11'd600;
                    end
                    LVL_HIGH: begin
                        on_len  = 11'd200;
                        off_len = 11'd200;
                    end
                    default: begin
                        timed = 1'b0;
                    end
                endcase
            end
            // With no level, no fault and no lock the buzzer is silenced but its phase is kept.
            if (!timed) begin
                bz_level = 1'b0;
            end else begin
                bz_timer = bz_timer + 11'd1;
                if (!bz_silent) begin
                    bz_level = ~bz_level;
                    if (bz_timer >= on_len) begin
                        bz_timer  = '0;
                        bz_silent = 1'b1;
                        bz_level  = 1'b0;
                    end
                end else begin
                    bz_level = 1'b0;
                    if (bz_timer >= off_len) begin
                        bz_timer  = '0;
                        bz_silent = 1'b0;
                    end
                end
            end
        end

        if (!tick_cnt[0]) begin
            r.timebase.scan_strobe = 1'b1;
            r.timebase.scan_digit  = digit_sel;
            r.timebase.scan_value  = dg[digit_sel];
            digit_sel = digit_sel + 2'd1;
        end

        led_cnt = led_cnt + 16'd1;
        if (!st.alarm_active) begin
            led_lv  = 3'b001;
            led_cnt = '0;
        end else begin
            alarm_lit = led_lv[1];
            fault_lit = led_lv[2];
            if (st.run_state == RUN_FAULT || st.run_state == RUN_LOCKED) begin
                if (led_cnt >= ((st.run_state == RUN_LOCKED) ? 200 : 1000)) begin
                    // Both LEDs follow the new alarm LED level.
                    alarm_lit = ~alarm_lit;
                    fault_lit = alarm_lit;
                    led_cnt   = '0;
                end
            end else if (st.severity == LVL_LOW || st.severity == LVL_MID) begin
                if (led_cnt >= ((st.severity == LVL_LOW) ? 1000 : 500)) begin
                    alarm_lit = ~alarm_lit;
                    fault_lit = 1'b0;
                    led_cnt   = '0;
                end
            end else if (st.severity == LVL_HIGH) begin
                if (led_cnt >= 200) begin
                    alarm_lit = 1'b0;
                    fault_lit = ~fault_lit;
                    led_cnt   = '0;
                end
            end
            led_lv = {fault_lit, alarm_lit, 1'b0};
        end

        r.timebase.pulse_10ms  = (tick_cnt % 20 == 0);
        r.timebase.pulse_100ms = (tick_cnt % 200 == 0);
        r.timebase.pulse_500ms = (tick_cnt % 1000 == 0);
        r.timebase.pulse_1s    = (tick_cnt % 2000 == 0);
        r.timebase.pulse_2s    = (tick_cnt % 4000 == 0);
        if (r.timebase.pulse_2s) begin
            tick_cnt = '0;
        end

        r.buzzer_out = bz_level;
        r.led_normal = led_lv[0];
        r.led_alarm  = led_lv[1];
        r.led_fault  = led_lv[2];
        return r;
    endfunction

    function automatic string differing_fields(t_tick_result e, t_tick_result a);
        string s;
        s = "";
        if (e.buzzer_out != a.buzzer_out) s = {s, " buzzer_out"};
        if (e.led_normal != a.led_normal) s = {s, " led_normal"};
        if (e.led_alarm != a.led_alarm) s = {s, " led_alarm"};
        if (e.led_fault != a.led_fault) s = {s, " led_fault"};
        if (e.timebase.scan_strobe != a.timebase.scan_strobe) s = {s, " scan_strobe"};
        if (e.timebase.scan_digit != a.timebase.scan_digit) s = {s, " scan_digit"};
        if (e.timebase.scan_value != a.timebase.scan_value) s = {s, " scan_value"};
        if (e.timebase.pulse_10ms != a.timebase.pulse_10ms) s = {s, " pulse_10ms"};
        if (e.timebase.pulse_100ms != a.timebase.pulse_100ms) s = {s, " pulse_100ms"};
        if (e.timebase.pulse_500ms != a.timebase.pulse_500ms) s = {s, " pulse_500ms"};
        if (e.timebase.pulse_1s != a.timebase.pulse_1s) s = {s, " pulse_1s"};
        if (e.timebase.pulse_2s != a.timebase.pulse_2s) s = {s, " pulse_2s"};
        return s;
    endfunction

    // Driver: a new beat is offered only once the previous one has been taken.
    always @(negedge i_clk) begin : driver
        t_tick_item nxt;
        if (i_rst_n && (!i_valid || in_fire)) begin
            if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_ticks.pop_front();
                i_valid        <= 1'b1;
                i_alarm_active <= nxt.status.alarm_active;
                i_run_state    <= nxt.status.run_state;
                i_severity     <= nxt.status.severity;
                i_digit0       <= nxt.digits[0];
                i_digit1       <= nxt.digits[1];
                i_digit2       <= nxt.digits[2];
                i_digit3       <= nxt.digits[3];
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : receiver
        if (holds_served != hold_requests) begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES;
            i_ready      <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin : monitor
        t_tick_result want;
        t_tick_result got;
        string        bad;
        in_fire <= i_valid && o_ready;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                buzzer_en = i_cfg_wdata;
            end
            if (i_valid && o_ready) begin
                expected_outputs.push_back(advance_tick(
                    {i_alarm_active, i_run_state, i_severity},
                    {i_digit3, i_digit2, i_digit1, i_digit0}));
                ticks_sent++;
            end
            if (o_valid && i_ready) begin
                got.buzzer_out           = o_buzzer_out;
                got.led_normal           = o_led_normal;
                got.led_alarm            = o_led_alarm;
                got.led_fault            = o_led_fault;
                got.timebase.scan_strobe = o_scan_strobe;
                got.timebase.scan_digit  = o_scan_digit;
                got.timebase.scan_value  = o_scan_value;
                got.timebase.pulse_10ms  = o_pulse_10ms;
                got.timebase.pulse_100ms = o_pulse_100ms;
                got.timebase.pulse_500ms = o_pulse_500ms;
                got.timebase.pulse_1s    = o_pulse_1s;
                got.timebase.pulse_2s    = o_pulse_2s;
                if (expected_outputs.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("ERROR: result beat %h arrived with nothing expected", got);
                    end
                end else begin
                    want = expected_outputs.pop_front();
                    bad  = differing_fields(want, got);
                    if (bad != "") begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT) begin
                            $display("ERROR: result %0d differs in%s: expected %h, got %h",
                                     checked_count, bad, want, got);
                        end
                    end
                    checked_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("ERROR: no beat moved for %0d cycles", WATCHDOG_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic queue_tick(logic act, logic [1:0] rs, logic [1:0] lvl, t_digits dg);
        t_tick_item it;
        it.status.alarm_active = act;
        it.status.run_state    = rs;
        it.status.severity     = lvl;
        it.digits              = dg;
        pending_ticks.push_back(it);
    endtask

    // Mostly long runs of one status so that blink and buzzer phases complete,
    // with short bursts of fully random status in between.
    task automatic queue_random_ticks(int count);
        int         left;
        int         run_len;
        int         k;
        bit         noisy;
        t_tick_item it;
        left = count;
        while (left > 0) begin
            noisy   = ($urandom_range(9) < 2);
            run_len = noisy ? $urandom_range(1, 6) : $urandom_range(20, 450);
            if (run_len > left) begin
                run_len = left;
            end
            it.status.alarm_active = ($urandom_range(9) != 0);
            it.status.run_state    = 2'($urandom_range(3));
            it.status.severity     = 2'($urandom_range(3));
            for (k = 0; k < run_len; k++) begin
                if (noisy) begin
                    it.status = t_status'($urandom());
                end
                it.digits = t_digits'($urandom());
                pending_ticks.push_back(it);
            end
            left -= run_len;
        end
    endtask

    task automatic wait_idle();
        do begin
            @(posedge i_clk);
        end while (pending_ticks.size() != 0 || i_valid || expected_outputs.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_buzzer_enable(logic value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_phase(int send_pct, int stall, logic enable, int count, bit squeeze);
        write_buzzer_enable(enable);
        send_idle_pct = send_pct;
        stall_pct     = stall;
        if (squeeze) begin
            hold_requests = hold_requests + 1;
        end
        queue_random_ticks(count);
        wait_idle();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        queue_tick(1'b0, RUN_OTHER,  LVL_NONE, 16'h0000);
        queue_tick(1'b1, RUN_OTHER,  LVL_HIGH, 16'hFFFF);
        queue_tick(1'b1, RUN_OTHER,  LVL_HIGH, 16'h9999);
        queue_tick(1'b1, RUN_OTHER,  LVL_HIGH, 16'hFEDC);
        queue_tick(1'b1, RUN_OTHER,  LVL_NONE, 16'hBA98);
        queue_tick(1'b1, RUN_OTHER,  LVL_NONE, 16'h7654);
        queue_tick(1'b1, RUN_OTHER,  LVL_HIGH, 16'h3210);
        queue_tick(1'b1, RUN_FAULT,  LVL_NONE, 16'h0A0F);
        queue_tick(1'b1, RUN_FAULT,  LVL_HIGH, 16'hB1C2);
        queue_tick(1'b1, RUN_LOCKED, LVL_LOW,  16'hD3E4);
        queue_tick(1'b1, RUN_LOCKED, LVL_MID,  16'h5F6A);
        queue_tick(1'b1, RUN_SPARE,  LVL_LOW,  16'h7B8C);
        queue_tick(1'b1, RUN_SPARE,  LVL_MID,  16'h9DAE);
        queue_tick(1'b1, RUN_SPARE,  LVL_NONE, 16'hF000);
        queue_tick(1'b1, RUN_SPARE,  LVL_HIGH, 16'h0F00);
        queue_tick(1'b0, RUN_SPARE,  LVL_HIGH, 16'h00F0);
        queue_tick(1'b0, RUN_LOCKED, LVL_MID,  16'h000F);
        queue_tick(1'b1, RUN_OTHER,  LVL_LOW,  16'h1248);
        queue_tick(1'b1, RUN_OTHER,  LVL_MID,  16'h8421);
        queue_tick(1'b0, RUN_FAULT,  LVL_LOW,  16'h5A5A);
        wait_idle();

        run_phase(0,  0,  1'b1, 350, 1'b0);
        run_phase(63, 0,  1'b0, 200, 1'b0);
        run_phase(0,  63, 1'b1, 400, 1'b1);
        run_phase(26, 26, 1'b1, 400, 1'b0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        mismatch_count = mismatch_count + expected_outputs.size();
        $display("Run summary: %0d ticks through open, sender-idle, receiver-stall and mixed",
                 ticks_sent);
        $display("traffic, buzzer muted and enabled; %0d results checked, %0d mismatches.",
                 checked_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/aatc_pkg.sv
rtl/aatc_timebase.sv
rtl/aatc_buzzer.sv
rtl/aatc_led.sv
rtl/alarm_annunciator_tick_controller.sv
dv/tb_alarm_annunciator_tick_controller.sv
